// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed: implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== design/ltfa_pkg.sv =====
// Types and constants for the loop tap frame address block.
package ltfa_pkg;

  localparam int ADDR_BITS_DEF = 24;
  localparam int TAP_BITS_DEF  = 32;

  typedef enum logic [1:0] {
    MODE_FORWARD  = 2'd0,
    MODE_ONESHOT  = 2'd1,
    MODE_REVERSE  = 2'd2,
    MODE_PINGPONG = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_LOOP_START = 2'd0,
    REG_LOOP_END   = 2'd1,
    REG_SRC_LEN    = 2'd2,
    REG_PLAY_MODE  = 2'd3
  } reg_idx_t;

  // How the final stage forms the index.
  typedef enum logic [1:0] {
    KIND_ZERO  = 2'd0,
    KIND_CLAMP = 2'd1,
    KIND_START = 2'd2,
    KIND_DIV   = 2'd3
  } kind_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  below;
  } side_t;

endpackage

// ===== design/loop_tap_frame_address_top.sv =====
// Loop tap frame address: tap frame number to sample-memory frame index.
// Throughput: one word per cycle while the output is not stalled; the pipeline
// holds one restoring-divider stage per dividend bit, each a single compare
// and subtract.
// Stalls freeze the whole pipeline; nothing is dropped or repeated.
// Reset (rst, synchronous) clears all valid bits and the configuration registers to zero.
module loop_tap_frame_address_top
  import ltfa_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  parameter int TAP_BITS  = TAP_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // configuration
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [ADDR_BITS:0]   cfg_data,
  // input words
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [((TAP_BITS+7)/8)*8-1:0]  s_axis_tdata,  // [TAP_BITS-1:0] tap_frame
  // result words
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [((ADDR_BITS+7)/8)*8-1:0] m_axis_tdata   // [ADDR_BITS-1:0] frame_index
);

`include "assert_macros.svh"

  localparam int A  = ADDR_BITS;
  localparam int T  = TAP_BITS;
  localparam int DW = ((A > T) ? A : T) + 1;  // dividend width
  localparam int OW = ((A+7)/8)*8;

  // configuration registers
  logic [A-1:0] loop_start;
  logic [A:0]   loop_end;
  logic [A:0]   source_length;
  mode_t        play_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_start    <= '0;
      loop_end      <= '0;
      source_length <= '0;
      play_mode     <= MODE_FORWARD;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_LOOP_START: loop_start    <= cfg_data[A-1:0];
        REG_LOOP_END:   loop_end      <= cfg_data;
        REG_SRC_LEN:    source_length <= cfg_data;
        REG_PLAY_MODE:  play_mode     <= mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // Derived config terms; the user must keep registers static while words are in flight (not enforced).
  logic [A:0] start_x, loop_len, span, last, divisor;
  logic       degen, pingpong, clamp_mode;
  always_comb begin
    start_x    = {1'b0, loop_start};
    degen      = (source_length == '0) || (start_x >= source_length) ||
                 (loop_end <= start_x);
    loop_len   = loop_end - start_x;
    span       = loop_len - 1'b1;
    last       = ((loop_end < source_length) ? loop_end : source_length) - 1'b1;
    pingpong   = (play_mode == MODE_PINGPONG);
    clamp_mode = (play_mode == MODE_ONESHOT) || (play_mode == MODE_REVERSE);
    divisor    = pingpong ? span : loop_len;
    if (divisor == '0) divisor = {{A{1'b0}}, 1'b1};
  end

  // Whole pipeline advances together when the output can move.
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: capture tap
  logic         v1;
  logic [T-1:0] tap1;
  // stage 2: sign and magnitude
  logic         v2, neg2;
  logic [T-1:0] mag2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tap1 <= s_axis_tdata[T-1:0];
      neg2 <= tap1[T-1];
      mag2 <= tap1[T-1] ? (~tap1 + 1'b1) : tap1;
    end
  end

  // distance from loop start, clamp value and kind, from stage 2
  logic [DW-1:0] mag_x, st_x, distance;
  logic          below;
  logic [A-1:0]  clamp_val;
  kind_t         kind;
  always_comb begin
    mag_x = DW'(mag2);
    st_x  = DW'(loop_start);
    if (neg2) begin
      below    = 1'b1;
      distance = st_x + mag_x;
    end else if (mag_x >= st_x) begin
      below    = 1'b0;
      distance = mag_x - st_x;
    end else begin
      below    = 1'b1;
      distance = st_x - mag_x;
    end
    if (neg2 || mag_x < st_x)       clamp_val = loop_start;
    else if (mag_x > DW'(last))     clamp_val = last[A-1:0];
    else                            clamp_val = mag_x[A-1:0];
    if (degen)                      kind = KIND_ZERO;
    else if (clamp_mode)            kind = KIND_CLAMP;
    else if (pingpong && span == '0) kind = KIND_START;
    else                            kind = KIND_DIV;
  end

  // divider stages: index 0 is the entry register, DW the last
  side_t         dv_side [DW+1];
  logic [DW-1:0] dv_num  [DW+1];
  logic [A:0]    dv_rem  [DW+1];
  logic          dv_q    [DW+1];
  logic [A-1:0]  dv_clamp[DW+1];

  logic [A+1:0]  trial   [DW];
  logic          ge      [DW];
  always_comb begin
    for (int k = 0; k < DW; k++) begin
      trial[k] = {dv_rem[k], dv_num[k][DW-1]};
      ge[k]    = trial[k] >= {1'b0, divisor};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DW; k++) dv_side[k].valid <= 1'b0;
    end else if (en) begin
      dv_side[0].valid <= v2;
      for (int k = 1; k <= DW; k++) dv_side[k].valid <= dv_side[k-1].valid;
    end
    if (en) begin
      dv_side[0].kind  <= kind;
      dv_side[0].below <= below;
      dv_num[0]        <= distance;
      dv_rem[0]        <= '0;
      dv_q[0]          <= 1'b0;
      dv_clamp[0]      <= clamp_val;
      for (int k = 1; k <= DW; k++) begin
        dv_side[k].kind  <= dv_side[k-1].kind;
        dv_side[k].below <= dv_side[k-1].below;
        dv_clamp[k]      <= dv_clamp[k-1];
        dv_num[k]        <= dv_num[k-1] << 1;
        dv_q[k]          <= ge[k-1];
        dv_rem[k]        <= ge[k-1] ? (A+1)'(trial[k-1] - {1'b0, divisor})
                                    : trial[k-1][A:0];
      end
    end
  end

  // final stage: fold or wrap the remainder, add loop start
  logic [A:0]   rem_f, offset;
  logic [A-1:0] index_next;
  always_comb begin
    rem_f = dv_rem[DW];
    if (pingpong)
      offset = dv_q[DW] ? (span - rem_f) : rem_f;  // odd fold count runs backward
    else if (dv_side[DW].below && rem_f != '0)
      offset = loop_len - rem_f;
    else
      offset = rem_f;
    case (dv_side[DW].kind)
      KIND_ZERO:  index_next = '0;
      KIND_CLAMP: index_next = dv_clamp[DW];
      KIND_START: index_next = loop_start;
      KIND_DIV:   index_next = loop_start + offset[A-1:0];
      default:    index_next = '0;
    endcase
  end

  logic [A-1:0] frame_index;
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= dv_side[DW].valid;
  end
  always_ff @(posedge clk) begin
    if (en) frame_index <= index_next;
  end
  assign m_axis_tdata = OW'(frame_index);

  // checks
  `ASSERT_IMPLIES(a_degen_zero, clk, rst, m_axis_tvalid && degen, frame_index == '0)
  `ASSERT_IMPLIES(a_clamp_range, clk, rst, m_axis_tvalid && !degen && clamp_mode,
                  frame_index >= loop_start && {1'b0, frame_index} <= last)
  `ASSERT_IMPLIES(a_pp_range, clk, rst, m_axis_tvalid && !degen && pingpong,
                  frame_index >= loop_start && {1'b0, frame_index} < loop_end)

endmodule
